// ----- rtl/dtr_pkg.sv -----
// ----------------------------------------------------------------------------
// dtr_pkg: shared types and helpers for the divider timer
// Item codes, register selects, stage structs and the edge-bit tap select.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int DIV_W  = 16;
    localparam int BYTE_W = 8;
    localparam int CTRL_W = 3;
    localparam int DLY_W  = 3;

    localparam logic [BYTE_W-1:0] CTRL_READ_ONES = 8'hF8;

    localparam logic [DLY_W-1:0] DLY_IRQ    = 3'd4;
    localparam logic [DLY_W-1:0] DLY_RELOAD = 3'd5;
    localparam logic [DLY_W-1:0] DLY_DONE   = 3'd6;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SEL_DIV  = 2'd0,
        SEL_TIMA = 2'd1,
        SEL_TMA  = 2'd2,
        SEL_TAC  = 2'd3
    } t_sel;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        reg_select;
        logic [BYTE_W-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              timer_irq;
    } t_result;

    // Divider tap selected by control[1:0]: bits 9, 3, 5, 7.
    function automatic logic edge_tap(input logic [DIV_W-1:0] div,
                                      input logic [1:0] rate);
        logic b;
        case (rate)
            2'd0:    b = div[9];
            2'd1:    b = div[3];
            2'd2:    b = div[5];
            2'd3:    b = div[7];
            default: b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/divider_timer_with_reload_delay.sv -----
// ----------------------------------------------------------------------------
// divider_timer_with_reload_delay: divider and timer with delayed reload
// Input register, single-pass state update, output register.
// ----------------------------------------------------------------------------
// The result is registered in the output register when the state update fires.
// Throughput: one item per cycle unless the output stalls; the state update is
// one pass of increments and compares between the input and output registers.
// Reset: synchronous active-low i_rst_n clears all timer state and both
// stage valids; the block accepts items as soon as reset is released.
module divider_timer_with_reload_delay (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [1:0] i_reg_select,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_timer_irq
);

    dtr_pkg::t_item   in_item;
    dtr_pkg::t_item   stage_item;
    dtr_pkg::t_result core_res;
    dtr_pkg::t_result r_res;
    logic             stage_valid;
    logic             advance;
    logic             fire;
    logic             r_out_valid;
    logic             n_out_valid;

    assign in_item.kind       = i_kind;
    assign in_item.reg_select = i_reg_select;
    assign in_item.write_data = i_write_data;

    // Advance when the output register is empty or being taken.
    assign advance = !r_out_valid || !i_out_stall;
    assign fire    = stage_valid && advance;

    dtr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    dtr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = stage_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_res.read_data;
    assign o_timer_irq = r_res.timer_irq;

endmodule

// ----- rtl/dtr_in_reg.sv -----
// ----------------------------------------------------------------------------
// dtr_in_reg: input register
// Captures one item per cycle while not stalled and holds it until the core stage advances.
// ----------------------------------------------------------------------------
module dtr_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dtr_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output dtr_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    dtr_pkg::t_item r_item;
    logic           load;

    assign o_stall = r_valid && !i_advance;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/dtr_core.sv -----
// ----------------------------------------------------------------------------
// dtr_core: timer state and per-item update
// Divider, counter, modulo, control and the overflow reload delay.
// ----------------------------------------------------------------------------
module dtr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  dtr_pkg::t_item  i_item,
    output dtr_pkg::t_result o_result
);

    logic [dtr_pkg::DIV_W-1:0]  r_div,  n_div;
    logic [dtr_pkg::BYTE_W-1:0] r_tima, n_tima;
    logic [dtr_pkg::BYTE_W-1:0] r_tma,  n_tma;
    logic [dtr_pkg::CTRL_W-1:0] r_tac,  n_tac;
    logic                       r_last, n_last;
    logic                       r_ovf,  n_ovf;
    logic [dtr_pkg::DLY_W-1:0]  r_dly,  n_dly;

    logic [dtr_pkg::DIV_W-1:0]  div_load;
    logic                       do_load;
    logic                       tap;
    logic                       fall;
    logic [dtr_pkg::BYTE_W-1:0] tima_inc;
    dtr_pkg::t_result           res;

    always_comb begin
        n_div  = r_div;
        n_tima = r_tima;
        n_tma  = r_tma;
        n_tac  = r_tac;
        n_last = r_last;
        n_ovf  = r_ovf;
        n_dly  = r_dly;
        res    = '0;

        do_load  = 1'b0;
        div_load = r_div + dtr_pkg::DIV_W'(1);
        case (i_item.kind)
            dtr_pkg::KIND_TICK: begin
                do_load = 1'b1;
            end
            dtr_pkg::KIND_WRITE: begin
                if (i_item.reg_select == dtr_pkg::SEL_DIV) begin
                    do_load  = 1'b1;
                    div_load = '0;
                end
            end
            default: begin
                do_load = 1'b0;
            end
        endcase

        tap      = dtr_pkg::edge_tap(div_load, r_tac[1:0]) && r_tac[2];
        fall     = do_load && !tap && r_last;
        tima_inc = r_tima + dtr_pkg::BYTE_W'(1);

        if (do_load) begin
            n_div  = div_load;
            n_last = tap;
        end
        // Count on a falling edge; a wrap to zero starts the reload delay.
        if (fall) begin
            n_tima = tima_inc;
            if (tima_inc == '0) begin
                n_ovf = 1'b1;
                n_dly = '0;
            end
        end

        case (i_item.kind)
            dtr_pkg::KIND_TICK: begin
                if (n_ovf) begin
                    n_dly = n_dly + dtr_pkg::DLY_W'(1);
                    if (n_dly == dtr_pkg::DLY_IRQ) begin
                        res.timer_irq = 1'b1;
                    end
                    if (n_dly == dtr_pkg::DLY_RELOAD) begin
                        n_tima = r_tma;
                    end
                    if (n_dly == dtr_pkg::DLY_DONE) begin
                        n_tima = r_tma;
                        n_ovf  = 1'b0;
                        n_dly  = '0;
                    end
                end
            end
            dtr_pkg::KIND_READ: begin
                case (i_item.reg_select)
                    dtr_pkg::SEL_DIV:  res.read_data = r_div[dtr_pkg::DIV_W-1 -: dtr_pkg::BYTE_W];
                    dtr_pkg::SEL_TIMA: res.read_data = r_tima;
                    dtr_pkg::SEL_TMA:  res.read_data = r_tma;
                    dtr_pkg::SEL_TAC:  res.read_data = dtr_pkg::CTRL_READ_ONES
                                       | dtr_pkg::BYTE_W'(r_tac);
                    default:           res.read_data = '0;
                endcase
            end
            dtr_pkg::KIND_WRITE: begin
                case (i_item.reg_select)
                    dtr_pkg::SEL_TIMA: begin
                        // Drop the write once the reload has begun.
                        if (r_dly < dtr_pkg::DLY_RELOAD) begin
                            n_tima = i_item.write_data;
                            n_ovf  = 1'b0;
                            n_dly  = '0;
                        end
                    end
                    dtr_pkg::SEL_TMA: n_tma = i_item.write_data;
                    dtr_pkg::SEL_TAC: n_tac = i_item.write_data[dtr_pkg::CTRL_W-1:0];
                    default: begin
                        n_tac = r_tac;
                    end
                endcase
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= '0;
            r_tima <= '0;
            r_tma  <= '0;
            r_tac  <= '0;
            r_last <= 1'b0;
            r_ovf  <= 1'b0;
            r_dly  <= '0;
        end else if (i_fire) begin
            r_div  <= n_div;
            r_tima <= n_tima;
            r_tma  <= n_tma;
            r_tac  <= n_tac;
            r_last <= n_last;
            r_ovf  <= n_ovf;
            r_dly  <= n_dly;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/dtr_checker.sv -----
// ----------------------------------------------------------------------------
// dtr_checker: port-level checks for the divider timer
// Watches the top-level ports and flags protocol and result slips.
// ----------------------------------------------------------------------------
module dtr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_data,
    input logic       o_timer_irq
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_timer_irq))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // Input stalls only while a finished result waits downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_irq |-> o_read_data == 8'h00)
        else $error("interrupt result carries read data");

    // An interrupt needs a fresh overflow, so two never come back to back.
    a_irq_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timer_irq && !i_out_stall |=> !(o_out_valid && o_timer_irq))
        else $error("back-to-back interrupt results");

endmodule

bind divider_timer_with_reload_delay dtr_checker u_dtr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data),
    .o_timer_irq (o_timer_irq)
);
